/* hdl/eddbl_pkg.sv */
// eddbl_pkg: shared widths, pixel and neighborhood types, and register
// indexes for the edge-directed pixel doubler.
// No dependencies; used by every module of the block except eddbl_ram.
package eddbl_pkg;

    // Field widths
    localparam int PIX_W         = 40;
    localparam int ARGB_W        = 32;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = ARGB_W / CHAN_W;
    localparam int COL_OUT_W     = 11;
    localparam int ROW_W         = 16;
    localparam int WIDTH_REG_W   = 12;
    localparam int HEIGHT_REG_W  = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 1;
    localparam int OUT_FIELDS_W  = COL_OUT_W + ROW_W + 4 * PIX_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    // Line-store organization: three rotating rows, each kept in three
    // copies so that left, center and right neighbors read in the same cycle
    localparam int NUM_STORES    = 3;
    localparam int NUM_COPIES    = 3;
    localparam int STORE_SEL_W   = 2;

    localparam int DEF_MAX_WIDTH = 2048;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] t_pixel;

    // Center pixel E with its four neighbors
    typedef struct packed {
        t_pixel b;
        t_pixel d;
        t_pixel e;
        t_pixel f;
        t_pixel h;
    } t_nbhd;

    // One 2x2 output block
    typedef struct packed {
        t_pixel tl;
        t_pixel tr;
        t_pixel bl;
        t_pixel br;
    } t_quad;

endpackage

/* hdl/eddbl_ram.sv */
// eddbl_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; instantiated for every line-store copy.
module eddbl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/eddbl_corner.sv */
// eddbl_corner: edge test and corner selection for one 2x2 output block.
// Depends on eddbl_pkg (t_nbhd, t_quad, channel widths).
module eddbl_corner (
    input  eddbl_pkg::t_nbhd i_nbhd,
    output eddbl_pkg::t_quad o_quad
);

    logic                            edge_hit;
    logic [eddbl_pkg::NUM_CHAN-1:0]  chan_hit;
    logic                            db_eq;
    logic                            bf_eq;
    logic                            dh_eq;
    logic                            hf_eq;

    // Edge: some channel differs both vertically and horizontally
    always_comb begin
        for (int i = 0; i < eddbl_pkg::NUM_CHAN; i++) begin
            chan_hit[i] =
                (i_nbhd.b[i*eddbl_pkg::CHAN_W +: eddbl_pkg::CHAN_W] !=
                 i_nbhd.h[i*eddbl_pkg::CHAN_W +: eddbl_pkg::CHAN_W]) &&
                (i_nbhd.d[i*eddbl_pkg::CHAN_W +: eddbl_pkg::CHAN_W] !=
                 i_nbhd.f[i*eddbl_pkg::CHAN_W +: eddbl_pkg::CHAN_W]);
        end
        edge_hit = |chan_hit;
    end

    // Neighbor pair matches, m byte ignored
    assign db_eq = i_nbhd.d[eddbl_pkg::ARGB_W-1:0] == i_nbhd.b[eddbl_pkg::ARGB_W-1:0];
    assign bf_eq = i_nbhd.b[eddbl_pkg::ARGB_W-1:0] == i_nbhd.f[eddbl_pkg::ARGB_W-1:0];
    assign dh_eq = i_nbhd.d[eddbl_pkg::ARGB_W-1:0] == i_nbhd.h[eddbl_pkg::ARGB_W-1:0];
    assign hf_eq = i_nbhd.h[eddbl_pkg::ARGB_W-1:0] == i_nbhd.f[eddbl_pkg::ARGB_W-1:0];

    // Corner selection
    assign o_quad.tl = (edge_hit && db_eq) ? i_nbhd.d : i_nbhd.e;
    assign o_quad.tr = (edge_hit && bf_eq) ? i_nbhd.f : i_nbhd.e;
    assign o_quad.bl = (edge_hit && dh_eq) ? i_nbhd.d : i_nbhd.e;
    assign o_quad.br = (edge_hit && hf_eq) ? i_nbhd.f : i_nbhd.e;

endmodule

/* hdl/edge_directed_pixel_doubler.sv */
// edge_directed_pixel_doubler: 2x edge-directed upscaler top level.
// Depends on eddbl_pkg, eddbl_ram and eddbl_corner.
//
// Takes one source pixel per clock in raster order while the working stage
// is free and returns 2x2 output blocks, one block per output transaction.
// The block of a pixel comes out when the pixel below it arrives, so the
// output trails the input by one row; on the bottom row each pixel past
// the first column also completes its left neighbor, and the final pixel
// of the image completes itself (flagged by tlast). An input pixel holds
// the input until every block it completes has moved on, since the single
// output register moves one block per clock while the output is not
// stalled. A pixel passes through the working stage and then the output
// register. Line stores are three rotating row memories, each held in
// three copies so the left, center and right neighbors read in the same
// clock; there is no clearing pass and no start-up delay after reset. Size
// registers take effect on the next pixel; write them between images.
module edge_directed_pixel_doubler #(
    parameter int MAX_WIDTH = eddbl_pkg::DEF_MAX_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  logic [eddbl_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [eddbl_pkg::CFG_W-1:0]            i_cfg_wdata,
    // Pixel input stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [eddbl_pkg::PIX_W-1:0]            i_s_axis_tdata,  // pixel[39:0]
    // Block output stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // src_col[10:0] src_row[26:11] top_left[66:27] top_right[106:67]
    // bottom_left[146:107] bottom_right[186:147], zero above
    output logic [eddbl_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tlast   // last_block
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Pending-block picks
    localparam logic [1:0] BLK_UPPER = 2'd0;  // block of the pixel above
    localparam logic [1:0] BLK_LEFT  = 2'd1;  // bottom row, left neighbor
    localparam logic [1:0] BLK_LAST  = 2'd2;  // final pixel of the image

    typedef logic [eddbl_pkg::STORE_SEL_W-1:0] t_store_sel;

    // Size registers, kept as last column / last row
    logic [COL_W-1:0]             r_w_last;
    logic [eddbl_pkg::ROW_W-1:0]  r_h_last;
    // Position of the next pixel
    logic [COL_W-1:0]             r_col_cnt,  n_col_cnt;
    logic [eddbl_pkg::ROW_W-1:0]  r_row_cnt,  n_row_cnt;
    t_store_sel                   r_cur,      n_cur;
    // Three most recent pixels, entry 0 newest
    eddbl_pkg::t_pixel            r_win [3];

    // Working stage
    logic                         r_s1_valid;
    logic [2:0]                   r_pend;
    logic [COL_W-1:0]             r_col;
    logic [eddbl_pkg::ROW_W-1:0]  r_row;
    logic                         r_c_ge1;
    logic                         r_c_ge2;
    logic                         r_c_lt_last;
    logic                         r_r_ge1;
    logic                         r_r_ge2;
    t_store_sel                   r_prev_sel;
    t_store_sel                   r_older_sel;

    // Output register
    logic                         r_out_valid;
    logic                         r_out_last;
    logic [COL_W-1:0]             r_out_col;
    logic [eddbl_pkg::ROW_W-1:0]  r_out_row;
    eddbl_pkg::t_quad             r_out_quad;

    logic                         accept;
    logic [COL_W-1:0]             c_eff;
    logic [eddbl_pkg::ROW_W-1:0]  r_eff;
    logic                         c_at_end;
    logic                         r_at_end;
    logic [COL_W-1:0]             rd_addr [eddbl_pkg::NUM_COPIES];
    eddbl_pkg::t_pixel            rd_data [eddbl_pkg::NUM_STORES][eddbl_pkg::NUM_COPIES];
    eddbl_pkg::t_pixel            prev_cm1;
    eddbl_pkg::t_pixel            prev_c;
    eddbl_pkg::t_pixel            prev_cp1;
    eddbl_pkg::t_pixel            older_c;
    logic [1:0]                   blk;
    logic [2:0]                   pend_low;
    logic [2:0]                   pend_rest;
    eddbl_pkg::t_nbhd             nbhd;
    eddbl_pkg::t_quad             quad;
    logic [COL_W-1:0]             blk_col;
    logic [eddbl_pkg::ROW_W-1:0]  blk_row;
    logic                         blk_last;
    logic                         out_free;
    logic                         out_load;
    logic                         s1_done;
    logic [31:0]                  cfg_w_wide;
    logic [31:0]                  out_col_wide;

    // Row store rotation, modulo three
    function automatic t_store_sel sel_inc(input t_store_sel s);
        t_store_sel res;
        unique case (s)
            2'd0:    res = 2'd1;
            2'd1:    res = 2'd2;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    //--------------------------------------------------------------------
    // Configuration: store width and height as last index, width saturated
    //--------------------------------------------------------------------
    assign cfg_w_wide = 32'(i_cfg_wdata[eddbl_pkg::WIDTH_REG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= '0;
            r_h_last <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                eddbl_pkg::REG_IMAGE_WIDTH: begin
                    if (cfg_w_wide == 32'd0) begin
                        r_w_last <= '0;
                    end else if (cfg_w_wide > 32'(MAX_WIDTH)) begin
                        r_w_last <= COL_W'(MAX_WIDTH - 1);
                    end else begin
                        r_w_last <= COL_W'(cfg_w_wide - 32'd1);
                    end
                end
                eddbl_pkg::REG_IMAGE_HEIGHT: begin
                    if (i_cfg_wdata[eddbl_pkg::HEIGHT_REG_W-1:0] == '0) begin
                        r_h_last <= '0;
                    end else begin
                        r_h_last <= eddbl_pkg::ROW_W'(
                            i_cfg_wdata[eddbl_pkg::HEIGHT_REG_W-1:0] - 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Input side: position, handshake, raster counters
    //--------------------------------------------------------------------
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign c_eff    = (r_col_cnt > r_w_last) ? r_w_last : r_col_cnt;
    assign r_eff    = (r_row_cnt > r_h_last) ? r_h_last : r_row_cnt;
    assign c_at_end = c_eff == r_w_last;
    assign r_at_end = r_eff == r_h_last;

    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        n_cur     = r_cur;
        if (accept) begin
            if (c_at_end) begin
                n_col_cnt = '0;
                n_row_cnt = r_at_end ? '0 : r_eff + 1'b1;
                n_cur     = sel_inc(r_cur);
            end else begin
                n_col_cnt = c_eff + 1'b1;
                n_row_cnt = r_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_cur     <= 2'd2;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
            r_cur     <= n_cur;
        end
    end

    // Pixel window shifts on every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (accept) begin
            r_win[0] <= i_s_axis_tdata;
            r_win[1] <= r_win[0];
            r_win[2] <= r_win[1];
        end
    end

    //--------------------------------------------------------------------
    // Line stores: write current row, read left/center/right
    //--------------------------------------------------------------------
    assign rd_addr[0] = c_eff - 1'b1;
    assign rd_addr[1] = c_eff;
    assign rd_addr[2] = c_eff + 1'b1;

    for (genvar s = 0; s < eddbl_pkg::NUM_STORES; s++) begin : g_store
        for (genvar k = 0; k < eddbl_pkg::NUM_COPIES; k++) begin : g_copy
            eddbl_ram #(
                .WIDTH (eddbl_pkg::PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (accept && (r_cur == eddbl_pkg::STORE_SEL_W'(s))),
                .i_waddr (c_eff),
                .i_wdata (i_s_axis_tdata),
                .i_re    (accept),
                .i_raddr (rd_addr[k]),
                .o_rdata (rd_data[s][k])
            );
        end
    end

    assign prev_cm1 = rd_data[r_prev_sel][0];
    assign prev_c   = rd_data[r_prev_sel][1];
    assign prev_cp1 = rd_data[r_prev_sel][2];
    assign older_c  = rd_data[r_older_sel][1];

    //--------------------------------------------------------------------
    // Working stage: what the accepted pixel completes
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pend     <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_pend     <= {r_at_end && c_at_end,
                           r_at_end && (c_eff != '0),
                           r_eff != '0};
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
            r_pend     <= '0;
        end else if (out_load) begin
            r_pend     <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col       <= c_eff;
            r_row       <= r_eff;
            r_c_ge1     <= c_eff != '0;
            r_c_ge2     <= (c_eff != '0) && (c_eff != COL_W'(1));
            r_c_lt_last <= !c_at_end;
            r_r_ge1     <= r_eff != '0;
            r_r_ge2     <= r_eff > eddbl_pkg::ROW_W'(1);
            r_prev_sel  <= sel_inc(sel_inc(r_cur));
            r_older_sel <= sel_inc(r_cur);
        end
    end

    // Oldest pending block goes first
    assign pend_low  = r_pend & (~r_pend + 1'b1);
    assign pend_rest = r_pend & ~pend_low;

    always_comb begin
        priority if (r_pend[0]) begin
            blk = BLK_UPPER;
        end else if (r_pend[1]) begin
            blk = BLK_LEFT;
        end else begin
            blk = BLK_LAST;
        end
    end

    // Neighborhood of the selected block, edges replaced by the center
    always_comb begin
        unique case (blk)
            BLK_UPPER: begin
                nbhd.e   = prev_c;
                nbhd.b   = r_r_ge2     ? older_c  : prev_c;
                nbhd.d   = r_c_ge1     ? prev_cm1 : prev_c;
                nbhd.f   = r_c_lt_last ? prev_cp1 : prev_c;
                nbhd.h   = r_win[0];
                blk_col  = r_col;
                blk_row  = r_row - 1'b1;
                blk_last = 1'b0;
            end
            BLK_LEFT: begin
                nbhd.e   = r_win[1];
                nbhd.b   = r_r_ge1 ? prev_cm1 : r_win[1];
                nbhd.d   = r_c_ge2 ? r_win[2] : r_win[1];
                nbhd.f   = r_win[0];
                nbhd.h   = r_win[1];
                blk_col  = r_col - 1'b1;
                blk_row  = r_row;
                blk_last = 1'b0;
            end
            default: begin
                nbhd.e   = r_win[0];
                nbhd.b   = r_r_ge1 ? prev_c   : r_win[0];
                nbhd.d   = r_c_ge1 ? r_win[1] : r_win[0];
                nbhd.f   = r_win[0];
                nbhd.h   = r_win[0];
                blk_col  = r_col;
                blk_row  = r_row;
                blk_last = 1'b1;
            end
        endcase
    end

    eddbl_corner u_corner (
        .i_nbhd (nbhd),
        .o_quad (quad)
    );

    //--------------------------------------------------------------------
    // Handshake between working stage and output register
    //--------------------------------------------------------------------
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign out_load        = r_s1_valid && (r_pend != '0) && out_free;
    assign s1_done         = r_s1_valid && ((r_pend == '0) || (out_load && (pend_rest == '0)));
    assign o_s_axis_tready = !r_s1_valid || s1_done;

    //--------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_col  <= blk_col;
            r_out_row  <= blk_row;
            r_out_quad <= quad;
            r_out_last <= blk_last;
        end
    end

    assign out_col_wide    = 32'(r_out_col);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{eddbl_pkg::OUT_PAD_W{1'b0}},
                              r_out_quad.br, r_out_quad.bl,
                              r_out_quad.tr, r_out_quad.tl,
                              r_out_row,
                              out_col_wide[eddbl_pkg::COL_OUT_W-1:0]};

endmodule

/* hdl/eddbl_checker.sv */
// eddbl_checker: port-level assertions for the pixel doubler, bound to the
// top level. Depends on eddbl_pkg for field widths.
module eddbl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [eddbl_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                              o_m_axis_tlast
);

    localparam int TL_LO = eddbl_pkg::COL_OUT_W + eddbl_pkg::ROW_W;
    localparam int TR_LO = TL_LO + eddbl_pkg::PIX_W;
    localparam int BL_LO = TR_LO + eddbl_pkg::PIX_W;
    localparam int BR_LO = BL_LO + eddbl_pkg::PIX_W;

    // No block is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled transaction holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // Final block: right and below are the center, so both right corners agree
    a_last_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            o_m_axis_tdata[TR_LO +: eddbl_pkg::PIX_W] ==
            o_m_axis_tdata[BR_LO +: eddbl_pkg::PIX_W])
        else $error("final block right corners differ");

    // Padding above the fields stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[eddbl_pkg::OUT_DATA_W-1:eddbl_pkg::OUT_FIELDS_W] == '0)
        else $error("padding bits set");

endmodule

bind edge_directed_pixel_doubler eddbl_checker u_eddbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* sim/edge_directed_pixel_doubler_test.sv */
// Self-checking testbench for edge_directed_pixel_doubler: drives pixel streams
// with random handshake gaps and checks every 2x2 output block.
// Depends on eddbl_pkg and the edge_directed_pixel_doubler RTL.
`timescale 1ns / 1ps

module edge_directed_pixel_doubler_test;
    import eddbl_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int TL_LSB        = COL_OUT_W + ROW_W;

    // Directed colors: Y and Y_M match on a, r, g, b but not on m
    localparam t_pixel C_X   = 40'h00_1122_3344;
    localparam t_pixel C_Y   = 40'hFF_AABB_CCDD;
    localparam t_pixel C_Y_M = 40'h00_AABB_CCDD;
    localparam t_pixel C_Z   = 40'hFF_FFFF_FFFF;

    typedef struct {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        t_pixel               tl;
        t_pixel               tr;
        t_pixel               bl;
        t_pixel               br;
        logic                 last;
    } t_block;

    // Predicts the 2x2 blocks from the accepted pixels and checks the results
    class t_upscale_scoreboard;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        t_pixel                  line_rows[NUM_STORES][MAX_W];
        int                      older_sel;
        int                      prev_sel;
        int                      cur_sel;
        int                      col_pos;
        int                      row_pos;
        t_pixel                  recent[3];
        t_block                  expected_blocks[$];
        int                      mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            older_sel  = 0;
            prev_sel   = 1;
            cur_sel    = 2;
            col_pos    = 0;
            row_pos    = 0;
            mismatches = 0;
            foreach (recent[k]) recent[k] = '0;
            foreach (line_rows[s, k]) line_rows[s][k] = '0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value[WIDTH_REG_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = value[HEIGHT_REG_W-1:0];
        endfunction

        // Edge-directed expansion of one center pixel e
        function t_block predict_block(int c, int r, t_pixel b, t_pixel d, t_pixel e,
                                       t_pixel f, t_pixel h, logic last);
            t_block blk;
            logic   crease;
            crease = 1'b0;
            for (int k = 0; k < NUM_CHAN; k++)
                if (b[k*CHAN_W +: CHAN_W] != h[k*CHAN_W +: CHAN_W] &&
                    d[k*CHAN_W +: CHAN_W] != f[k*CHAN_W +: CHAN_W])
                    crease = 1'b1;
            blk.col  = COL_OUT_W'(c);
            blk.row  = ROW_W'(r);
            blk.tl   = (crease && d[ARGB_W-1:0] == b[ARGB_W-1:0]) ? d : e;
            blk.tr   = (crease && b[ARGB_W-1:0] == f[ARGB_W-1:0]) ? f : e;
            blk.bl   = (crease && d[ARGB_W-1:0] == h[ARGB_W-1:0]) ? d : e;
            blk.br   = (crease && h[ARGB_W-1:0] == f[ARGB_W-1:0]) ? f : e;
            blk.last = last;
            return blk;
        endfunction

        // Accepted input pixel: store it and queue the blocks it completes
        function void take_pixel(t_pixel p);
            int     w;
            int     ht;
            int     c;
            int     r;
            int     spare;
            t_pixel e;
            t_pixel b;
            t_pixel d;
            t_pixel f;
            w  = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
            ht = (height_reg == 0) ? 1 : height_reg;
            if (col_pos >= w) col_pos = w - 1;
            if (row_pos >= ht) row_pos = ht - 1;
            c = col_pos;
            r = row_pos;
            line_rows[cur_sel][c] = p;
            recent[2] = recent[1];
            recent[1] = recent[0];
            recent[0] = p;

            // pixel below completes the block one row up
            if (r >= 1) begin
                e = line_rows[prev_sel][c];
                b = (r >= 2) ? line_rows[older_sel][c] : e;
                d = (c >= 1) ? line_rows[prev_sel][c-1] : e;
                f = (c + 1 < w) ? line_rows[prev_sel][c+1] : e;
                expected_blocks.push_back(predict_block(c, r - 1, b, d, e, f, p, 1'b0));
            end
            // bottom row: this pixel completes its left neighbor
            if (r == ht - 1 && c >= 1) begin
                e = recent[1];
                d = (c >= 2) ? recent[2] : e;
                b = (r >= 1) ? line_rows[prev_sel][c-1] : e;
                expected_blocks.push_back(predict_block(c - 1, r, b, d, e, p, e, 1'b0));
            end
            // final pixel of the image completes itself
            if (r == ht - 1 && c == w - 1) begin
                d = (c >= 1) ? recent[1] : p;
                b = (r >= 1) ? line_rows[prev_sel][c] : p;
                expected_blocks.push_back(predict_block(c, r, b, d, p, p, p, 1'b1));
            end

            col_pos = c + 1;
            if (col_pos >= w) begin
                spare     = older_sel;
                older_sel = prev_sel;
                prev_sel  = cur_sel;
                cur_sel   = spare;
                col_pos   = 0;
                row_pos   = r + 1;
                if (row_pos >= ht) row_pos = 0;
            end
        endfunction

        function void compare(string field, t_block want, t_pixel exp_val, t_pixel act_val);
            if (exp_val !== act_val) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: block (%0d,%0d) %s expected %h got %h", $realtime,
                             want.col, want.row, field, exp_val, act_val);
            end
        endfunction

        // Output transaction: compare against the oldest expected block
        function void check_block(logic [OUT_DATA_W-1:0] data, logic last);
            t_block want;
            if (expected_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected block, data %h last %b", $realtime, data, last);
                return;
            end
            want = expected_blocks.pop_front();
            compare("src_col", want, t_pixel'(want.col), t_pixel'(data[COL_OUT_W-1:0]));
            compare("src_row", want, t_pixel'(want.row), t_pixel'(data[COL_OUT_W +: ROW_W]));
            compare("top_left", want, want.tl, data[TL_LSB +: PIX_W]);
            compare("top_right", want, want.tr, data[TL_LSB + PIX_W +: PIX_W]);
            compare("bottom_left", want, want.bl, data[TL_LSB + 2*PIX_W +: PIX_W]);
            compare("bottom_right", want, want.br, data[TL_LSB + 3*PIX_W +: PIX_W]);
            compare("last_block", want, t_pixel'(want.last), t_pixel'(last));
        endfunction

        function int outstanding();
            return expected_blocks.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    t_pixel                 s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    t_upscale_scoreboard    sb;
    t_pixel                 palette[3];
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    int                     hold_left = 0;
    int                     sent_count = 0;
    int                     cycle_count = 0;

    edge_directed_pixel_doubler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: long hold-off when requested, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor
    always @(posedge i_clk)
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_block(m_tdata, m_tlast);

    function automatic void new_palette();
        foreach (palette[k]) palette[k] = {8'($urandom), 32'($urandom)};
        // one pair that differs in a single channel only
        if ($urandom_range(1))
            palette[2] = palette[1] ^ (t_pixel'(8'hFF) << (CHAN_W * $urandom_range(3)));
    endfunction

    // Mostly palette colors so neighbors match often; some noise
    function automatic t_pixel random_pixel();
        t_pixel p;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            p = {8'($urandom), 32'($urandom)};
        end else begin
            p = palette[$urandom_range(2)];
            if (pick < 40) p[PIX_W-1:ARGB_W] = 8'($urandom);
        end
        return p;
    endfunction

    task automatic send_pixel(input t_pixel pix);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge i_clk); while (!s_tready);
        sb.take_pixel(pix);
        sent_count++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(random_pixel());
    endtask

    // Stop offering, wait for all blocks and for the pipeline to settle
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Width register ignores the upper data bits; drive them at random
    task automatic set_size(input int w, input int h);
        drain();
        write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(15)), 12'(w)});
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    endtask

    task automatic run_images(input int w, input int h, input int n);
        int eff_w;
        int eff_h;
        set_size(w, h);
        eff_w = (w % 4096 == 0) ? 1 : ((w % 4096 > MAX_W) ? MAX_W : w % 4096);
        eff_h = (h == 0) ? 1 : h;
        repeat (n) begin
            new_palette();
            send_random(eff_w * eff_h);
        end
    endtask

    task automatic set_idling(input int send_pct, input int stall);
        drain();
        send_idle_pct = send_pct;
        stall_pct     = stall;
    endtask

    initial begin
        t_pixel diag[9];
        t_pixel chans[4];
        int     target;

        sb = new();
        diag  = '{C_X, C_X, C_Y, C_X, C_Y, C_Y_M, C_Y, C_Y_M, C_Z};
        chans = '{40'h00_0000_0000, 40'h00_0000_00FF, 40'h00_0000_FF00, 40'h7F_FF00_0000};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size is 1x1: every pixel is its own final block
        send_pixel('0);
        send_pixel(C_Z);
        send_pixel(40'hA5_5A3C_C3F0);

        // Diagonal edges, corner copies carry the m byte of the chosen pixel
        set_size(3, 3);
        foreach (diag[k]) send_pixel(diag[k]);

        // Zero sizes fall back to 1x1
        set_size(0, 0);
        send_pixel(C_Y);
        send_pixel(C_X);

        // Neighbor pairs differing in distinct channels only
        set_size(2, 2);
        foreach (chans[k]) send_pixel(chans[k]);

        // Random images under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(52, 0);
                2: set_idling(0, 52);
                default: set_idling(29, 29);
            endcase
            target = sent_count + 60;
            while (sent_count < target)
                run_images(($urandom_range(9) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(1, 8),
                           $urandom_range(1, 4), 1);
        end

        // Output held off while input keeps streaming: block must back up
        set_idling(0, 0);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        run_images(16, 4, 1);

        // Maximum height, then width shrinks mid-image (column saturates)
        set_idling(29, 29);
        set_size(6, 16'hFFFF);
        new_palette();
        send_random(2 * 6 + 4);
        set_size(3, 3);
        send_random(1);

        // Height shrinks below the current row (row saturates)
        set_size(2, 16'hFFFF);
        send_random(4 * 2);
        set_size(2, 2);
        send_random(2);

        // Width above the line store length saturates; row finished narrower
        set_size(4095, 2);
        new_palette();
        send_random(24);
        set_size(5, 2);
        send_random(1 + 5);
        run_images(1, 3, 1);

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
